// ===== rtl/llars_pkg.sv =====
// Shared types, constants and the next-generation function of the row-step automaton.
`default_nettype none

package llars_pkg;

    localparam int LLARS_ROW_W     = 64;   // fixed row field width
    localparam int LLARS_WIDTH     = 64;   // default active columns
    localparam int LLARS_JOB_DEPTH = 2;
    localparam int LLARS_RES_DEPTH = 2;
    localparam int LLARS_MASK_W    = 9;
    localparam int LLARS_CFG_IDX_W = 8;

    localparam logic [LLARS_MASK_W-1:0] LLARS_BIRTH_RST   = 9'd480;  // B5678
    localparam logic [LLARS_MASK_W-1:0] LLARS_SURVIVE_RST = 9'd496;  // S45678

    localparam logic [LLARS_CFG_IDX_W-1:0] CFG_BIRTH_MASK   = 8'd0;
    localparam logic [LLARS_CFG_IDX_W-1:0] CFG_SURVIVE_MASK = 8'd1;

    typedef logic [LLARS_ROW_W-1:0]  t_row;
    typedef logic [LLARS_MASK_W-1:0] t_mask;

    typedef struct packed {
        t_row row_cells;
        logic final_row;
    } t_in_item;

    typedef struct packed {
        t_row next_cells;
        logic last_out;
    } t_out_item;

    // One job: rows a/b/c give the first result ng(a,b,c);
    // with two set, a second result ng(b,c,0) follows.
    typedef struct packed {
        t_row row_a;
        t_row row_b;
        t_row row_c;
        logic two;
        logic last1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Next state of row mid; rows must already be zero beyond the active width.
    function automatic t_row next_gen(input t_row up, input t_row mid, input t_row dn,
                                      input t_mask birth, input t_mask survive);
        logic [LLARS_ROW_W+1:0] u;
        logic [LLARS_ROW_W+1:0] m;
        logic [LLARS_ROW_W+1:0] d;
        t_row                   res;
        logic [3:0]             n;
        t_mask                  rule;
        u = {1'b0, up, 1'b0};
        m = {1'b0, mid, 1'b0};
        d = {1'b0, dn, 1'b0};
        res = '0;
        for (int i = 0; i < LLARS_ROW_W; i++) begin
            n = 4'(u[i]) + 4'(u[i+1]) + 4'(u[i+2]) + 4'(m[i]) + 4'(m[i+2])
              + 4'(d[i]) + 4'(d[i+1]) + 4'(d[i+2]);
            rule = m[i+1] ? survive : birth;
            res[i] = rule[n];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/llars_fifo.sv =====
// Small register queue used between the stages and at the result side.
`default_nettype none

module llars_fifo
    import llars_pkg::*;
#(
    parameter int DW    = 1,
    parameter int DEPTH = LLARS_JOB_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_pop,
    output logic      [DW-1:0] o_rdata,
    output t_q_status          o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata        = r_mem[r_rptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/llars_front.sv =====
// Front stage: takes rows, keeps the row window and issues jobs.
`default_nettype none

module llars_front
    import llars_pkg::*;
#(
    parameter int WIDTH = LLARS_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_in_item  i_item,
    input  wire t_q_status i_job_status,
    output logic           o_full,
    output logic           o_job_push,
    output t_job           o_job
);

    localparam t_row WMASK = {LLARS_ROW_W{1'b1}} >> (LLARS_ROW_W - WIDTH);

    t_row r_above, n_above;
    t_row r_middle, n_middle;
    logic r_pending, n_pending;
    logic accept;
    t_row row;

    assign o_full = i_job_status.full;
    assign accept = i_push && !i_job_status.full;
    assign row    = i_item.row_cells & WMASK;

    always_comb begin
        n_above    = r_above;
        n_middle   = r_middle;
        n_pending  = r_pending;
        o_job_push = 1'b0;
        o_job      = '{row_a: r_above, row_b: r_middle, row_c: row,
                       two: i_item.final_row, last1: 1'b0};
        if (accept) begin
            if (!r_pending) begin
                if (i_item.final_row) begin
                    // single-row grid
                    o_job_push = 1'b1;
                    o_job      = '{row_a: '0, row_b: row, row_c: '0,
                                   two: 1'b0, last1: 1'b1};
                    n_above    = '0;
                    n_middle   = '0;
                end else begin
                    // first row: hold it, nothing owed yet
                    n_above   = '0;
                    n_middle  = row;
                    n_pending = 1'b1;
                end
            end else begin
                o_job_push = 1'b1;
                n_above    = r_middle;
                n_middle   = row;
                if (i_item.final_row) begin
                    n_above   = '0;
                    n_middle  = '0;
                    n_pending = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above   <= '0;
            r_middle  <= '0;
            r_pending <= 1'b0;
        end else begin
            r_above   <= n_above;
            r_middle  <= n_middle;
            r_pending <= n_pending;
        end
    end

`ifndef ASSERT_OFF
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.final_row) |=> !r_pending)
        else $error("row window still pending after final row");
    a_pending_issues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_pending) |-> o_job_push)
        else $error("held row accepted without job");
`endif

endmodule

`default_nettype wire

// ===== rtl/llars_back.sv =====
// Back stage: neighbor-count unit per job, one result row per cycle unless stalled.
`default_nettype none

module llars_back
    import llars_pkg::*;
#(
    parameter int WIDTH = LLARS_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_job,
    input  wire t_q_status i_job_status,
    input  wire t_q_status i_res_status,
    input  wire t_mask     i_birth,
    input  wire t_mask     i_survive,
    output logic           o_job_pop,
    output logic           o_res_push,
    output t_out_item      o_res
);

    localparam t_row WMASK = {LLARS_ROW_W{1'b1}} >> (LLARS_ROW_W - WIDTH);

    logic r_phase, n_phase;   // high: second result of a final-row job
    logic fire;
    t_row up, mid, dn;

    assign fire = !i_job_status.empty && !i_res_status.full;

    always_comb begin
        up  = r_phase ? i_job.row_b : i_job.row_a;
        mid = r_phase ? i_job.row_c : i_job.row_b;
        dn  = r_phase ? '0          : i_job.row_c;
    end

    always_comb begin
        o_res_push        = fire;
        o_res.next_cells  = next_gen(up, mid, dn, i_birth, i_survive) & WMASK;
        o_res.last_out    = r_phase || i_job.last1;
        o_job_pop         = fire && (r_phase || !i_job.two);
        n_phase           = r_phase;
        if (fire) begin
            n_phase = !r_phase && i_job.two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

`ifndef ASSERT_OFF
    a_phase_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_job_status.empty && i_job.two))
        else $error("second result without a two-result job");
`endif

endmodule

`default_nettype wire

// ===== rtl/life_like_automaton_row_step.sv =====
// Top level of the row-streamed Life-like automaton (B/S rule), one generation.
`default_nettype none

// Rows of a grid are pushed top first, one transaction per row; the block
// returns the next generation of each row once the row below it has arrived,
// and the row marked final_row returns both the row above it and itself
// (last_out set on the latter). A single-row grid gives one result. Cells
// outside the grid, including columns at or above WIDTH, count as dead and
// come back as zero. A row is accepted every cycle while full is low; a final
// row that follows other rows makes the shared neighbor-count unit in the back
// stage produce two results from that job, one after the other. The job queue
// between front and back stage absorbs that, since the first row of the next
// grid issues no job; while the result queue does not fill, only a single-row
// grid right behind such a final row sees full for one cycle.
// A result passes through the registered job queue and result queue before it
// reaches the result queue head; the second result of a final row follows it.
// The birth and survive masks reset to B5678/S45678 and are written through
// the configuration channel (index 0 birth, 1 survive, other indexes ignored),
// which is always ready; write them only while no row is in flight.

module life_like_automaton_row_step
    import llars_pkg::*;
#(
    parameter int WIDTH     = LLARS_WIDTH,
    parameter int JOB_DEPTH = LLARS_JOB_DEPTH,
    parameter int RES_DEPTH = LLARS_RES_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // input row queue side
    input  wire logic                       push,
    output logic                            full,
    input  wire t_in_item                   i_in_item,
    // result queue side
    output logic                            empty,
    input  wire logic                       pop,
    output t_out_item                       o_out_item,
    // configuration write channel
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [LLARS_CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [LLARS_MASK_W-1:0]    i_cfg_data
);

    t_mask     r_birth;
    t_mask     r_survive;

    t_job      job_in, job_out;
    logic      job_push, job_pop;
    t_q_status job_status;

    t_out_item res_in;
    logic      res_push;
    t_q_status res_status;

    // Rule registers; a transaction to an unknown index is dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth   <= LLARS_BIRTH_RST;
            r_survive <= LLARS_SURVIVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BIRTH_MASK:   r_birth   <= i_cfg_data;
                CFG_SURVIVE_MASK: r_survive <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front stage: row window and job issue.
    llars_front #(
        .WIDTH(WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_in_item),
        .i_job_status(job_status),
        .o_full      (full),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // Job queue decoupling front and back.
    llars_fifo #(
        .DW   ($bits(t_job)),
        .DEPTH(JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_wdata (job_in),
        .i_pop   (job_pop),
        .o_rdata (job_out),
        .o_status(job_status)
    );

    // Back stage: neighbor counts and rule lookup.
    llars_back #(
        .WIDTH(WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_out),
        .i_job_status(job_status),
        .i_res_status(res_status),
        .i_birth     (r_birth),
        .i_survive   (r_survive),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // Result queue; its head drives the output ports.
    llars_fifo #(
        .DW   ($bits(t_out_item)),
        .DEPTH(RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_in),
        .i_pop   (pop && !empty),
        .o_rdata (o_out_item),
        .o_status(res_status)
    );

    assign empty = res_status.empty;

endmodule

`default_nettype wire
